// ===== rtl/pms_pkg.sv =====
// shared types, widths and arithmetic helpers for the particle motion step core
// no dependencies
package pms_pkg;

  localparam int W          = 20;
  localparam int DATA_W     = 6 * W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int D_W        = W + 1;
  localparam int SQ_W       = 42;
  localparam int LEN_W      = 21;
  localparam int DIST_W     = 15;
  localparam int P1_W       = LEN_W + DIST_W;
  localparam int DEN_W      = P1_W + DIST_W;
  localparam int PROD_W     = 40;
  localparam int NUM_SH     = 24;
  localparam int NUM_W      = PROD_W + NUM_SH;
  localparam int Q_W        = 22;
  localparam int CMP_W      = DEN_W + Q_W + 1;
  localparam int K_W        = 14;
  localparam int SAT_W      = 40;
  localparam int SQRT_STG   = LEN_W;
  localparam int DIV_STG    = Q_W + 1;
  localparam int CARRY_LEN  = SQRT_STG + 2 + DIV_STG;
  localparam int WALL_STG   = 6;
  localparam int DIST_MIN   = 4096;
  localparam int DIST_MAX   = 20480;
  localparam int ONE_Q12    = 4096;
  localparam int MAXV       = (1 << (W - 1)) - 1;
  localparam int MINV       = -(1 << (W - 1));

  localparam int MODE_GRAV = 0;
  localparam int MODE_ATTR = 1;
  localparam int MODE_WALL = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 3'd0,
    CFG_GRAV = 3'd1,
    CFG_ATT  = 3'd2,
    CFG_STR  = 3'd3,
    CFG_HALF = 3'd4,
    CFG_RAD  = 3'd5,
    CFG_FRIC = 3'd6
  } cfg_idx_t;

  typedef logic [2:0][W-1:0] vec3_t;

  typedef struct packed {
    vec3_t                  p;
    vec3_t                  v;
    logic [2:0]             dneg;
    logic [2:0][PROD_W-1:0] prod;
  } carry_t;

  typedef struct packed {
    logic                  en;
    logic signed [W-1:0]   lim;
    logic signed [K_W-1:0] k;
  } wall_cfg_t;

  function automatic logic [W-1:0] sat20(input logic signed [SAT_W-1:0] x);
    logic [W-1:0] r;
    if (x > SAT_W'(MAXV)) r = W'(MAXV);
    else if (x < SAT_W'(MINV)) r = W'(MINV);
    else r = x[W-1:0];
    return r;
  endfunction

  function automatic logic [W-1:0] fscale(input logic [W-1:0] v, input logic [K_W-1:0] k,
                                          input logic neg);
    logic signed [SAT_W-1:0] prod, mag, q, r;
    prod = SAT_W'($signed(v)) * SAT_W'($signed(k));
    mag  = (prod < 0) ? -prod : prod;
    q    = mag >>> 12;
    r    = (prod < 0) ? -q : q;
    if (neg) r = -r;
    return sat20(r);
  endfunction

endpackage

// ===== rtl/pms_isqrt.sv =====
// pipelined integer square root, one result bit per stage
// depends on pms_pkg
module pms_isqrt import pms_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [SQ_W-1:0]  x_in,
  output logic [LEN_W-1:0] len_out
);

  logic [SQ_W-1:0] x_r   [SQRT_STG];
  logic [SQ_W-1:0] res_r [SQRT_STG];

  for (genvar g = 0; g < SQRT_STG; g++) begin : g_stg
    logic [SQ_W-1:0] xi, ri, bitv, trial, x_nxt, res_nxt;
    if (g == 0) begin : g_first
      assign xi = x_in;
      assign ri = '0;
    end else begin : g_next
      assign xi = x_r[g-1];
      assign ri = res_r[g-1];
    end
    assign bitv  = SQ_W'(1) << (2 * (SQRT_STG - 1 - g));
    assign trial = ri + bitv;
    always_comb begin
      if (xi >= trial) begin
        x_nxt   = xi - trial;
        res_nxt = (ri >> 1) + bitv;
      end else begin
        x_nxt   = xi;
        res_nxt = ri >> 1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[g]   <= x_nxt;
        res_r[g] <= res_nxt;
      end
    end
  end

  assign len_out = res_r[SQRT_STG-1][LEN_W-1:0];

endmodule

// ===== rtl/pms_div.sv =====
// pipelined restoring divider for the three attractor terms, shared divisor
// depends on pms_pkg; quotient saturates, zero divisor gives zero
module pms_div import pms_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [2:0][PROD_W-1:0] prod_in,
  input  logic [DEN_W-1:0]       den_in,
  output logic [2:0][Q_W-1:0]    q_out
);

  logic [DEN_W-1:0]       den_r [DIV_STG];
  logic [2:0][NUM_W-1:0]  rem_r [DIV_STG];
  logic [2:0][Q_W-1:0]    q_r   [DIV_STG];
  logic [2:0]             sat_r [DIV_STG];

  for (genvar g = 0; g < DIV_STG; g++) begin : g_stg
    localparam int B  = Q_W - g;
    localparam int BQ = (B < Q_W) ? B : 0;
    logic [DEN_W-1:0]      den_i;
    logic [2:0][NUM_W-1:0] rem_i, rem_nxt;
    logic [2:0][Q_W-1:0]   q_i, q_nxt;
    logic [2:0]            sat_i, sat_nxt;
    logic [CMP_W-1:0]      shd;
    if (g == 0) begin : g_first
      assign den_i = den_in;
      assign q_i   = '0;
      assign sat_i = '0;
      for (genvar l = 0; l < 3; l++) begin : g_ln
        assign rem_i[l] = NUM_W'(prod_in[l]) << NUM_SH;
      end
    end else begin : g_next
      assign den_i = den_r[g-1];
      assign rem_i = rem_r[g-1];
      assign q_i   = q_r[g-1];
      assign sat_i = sat_r[g-1];
    end
    assign shd = CMP_W'(den_i) << B;
    always_comb begin
      rem_nxt = rem_i;
      q_nxt   = q_i;
      sat_nxt = sat_i;
      for (int l = 0; l < 3; l++) begin
        if (CMP_W'(rem_i[l]) >= shd) begin
          if (g == 0) begin
            sat_nxt[l] = 1'b1;
          end else begin
            rem_nxt[l]   = rem_i[l] - shd[NUM_W-1:0];
            q_nxt[l][BQ] = 1'b1;
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g] <= den_i;
        rem_r[g] <= rem_nxt;
        q_r[g]   <= q_nxt;
        sat_r[g] <= sat_nxt;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (den_r[DIV_STG-1] == '0) q_out[l] = '0;
      else if (sat_r[DIV_STG-1][l]) q_out[l] = '1;
      else q_out[l] = q_r[DIV_STG-1][l];
    end
  end

endmodule

// ===== rtl/pms_walls.sv =====
// six ordered box wall checks with bounce and friction, one check per stage
// depends on pms_pkg; last stage is the output register
module pms_walls import pms_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  wall_cfg_t cfg,
  input  logic      vld_in,
  input  vec3_t     p_in,
  input  vec3_t     v_in,
  output logic      vld_out,
  output vec3_t     p_out,
  output vec3_t     v_out
);

  logic [WALL_STG-1:0] vld_r;
  vec3_t               p_r [WALL_STG];
  vec3_t               v_r [WALL_STG];
  logic signed [W-1:0] nlim;

  assign nlim = -cfg.lim;

  for (genvar g = 0; g < WALL_STG; g++) begin : g_stg
    localparam int AX   = g / 2;
    localparam int SIDE = g % 2;
    logic  vi, hit;
    vec3_t pi, vvi, p_nxt, v_nxt;
    if (g == 0) begin : g_first
      assign vi  = vld_in;
      assign pi  = p_in;
      assign vvi = v_in;
    end else begin : g_next
      assign vi  = vld_r[g-1];
      assign pi  = p_r[g-1];
      assign vvi = v_r[g-1];
    end
    always_comb begin
      if (SIDE == 0) hit = cfg.en && ($signed(pi[AX]) < nlim);
      else hit = cfg.en && ($signed(pi[AX]) > cfg.lim);
      p_nxt = pi;
      v_nxt = vvi;
      if (hit) begin
        p_nxt[AX] = (SIDE == 0) ? nlim : cfg.lim;
        for (int i = 0; i < 3; i++) v_nxt[i] = fscale(vvi[i], cfg.k, i == AX);
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= vi;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        p_r[g] <= p_nxt;
        v_r[g] <= v_nxt;
      end
    end
  end

  assign vld_out = vld_r[WALL_STG-1];
  assign p_out   = p_r[WALL_STG-1];
  assign v_out   = v_r[WALL_STG-1];

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r)) else $error("wall stage valids moved during stall");
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> vld_r[0] == $past(vld_in)) else $error("wall stage lost or invented a request");
  a_reset: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0) else $error("wall stage valids not cleared by reset");

endmodule

// ===== rtl/particle_motion_step_core.sv =====
// One explicit Euler step per particle: gravity, optional point attractor
// and optional bouncing box. One request is accepted every cycle while the
// output is free or being taken; each result passes through 2 entry stages,
// 21 square root stages, 2 divisor multiply stages, 23 divider stages,
// 2 integration stages and 6 wall stages. A stall on the output freezes
// the whole pipeline. Configuration is read live by the stages that use it.
module particle_motion_step_core import pms_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  input  logic [DATA_W-1:0]     in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
  output logic [DATA_W-1:0]     out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [2:0]    mode_r;
  logic [59:0]   grav_r, att_r;
  logic [W-1:0]  str_r;
  logic [18:0]   half_r, rad_r;
  logic [12:0]   fric_r;
  logic          en;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      grav_r <= '0;
      att_r  <= '0;
      str_r  <= '0;
      half_r <= 19'd16384;
      rad_r  <= 19'd410;
      fric_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_MODE: mode_r <= cfg_wdata[2:0];
        CFG_GRAV: grav_r <= cfg_wdata[59:0];
        CFG_ATT:  att_r  <= cfg_wdata[59:0];
        CFG_STR:  str_r  <= cfg_wdata[W-1:0];
        CFG_HALF: half_r <= cfg_wdata[18:0];
        CFG_RAD:  rad_r  <= cfg_wdata[18:0];
        CFG_FRIC: fric_r <= cfg_wdata[12:0];
        default: ;
      endcase
    end
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: offset to attractor
  logic                  vld1_r;
  vec3_t                 p1_r, v1_r;
  logic [2:0][D_W-1:0]   d1_r, d_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = D_W'($signed(att_r[i*W +: W])) - D_W'($signed(in_tdata[i*W +: W]));
    end
  end

  // stage 2: squares and numerator products
  logic                   vld2_r;
  vec3_t                  p2_r, v2_r;
  logic [2:0]             dneg2_r;
  logic [2:0][SQ_W-1:0]   sq2_r, sq_nxt;
  logic [2:0][PROD_W-1:0] prod2_r, prod_nxt;
  logic [2:0][D_W-1:0]    dmag;
  logic [W-1:0]           smag;

  assign smag = str_r[W-1] ? W'(-$signed(str_r)) : str_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dmag[i]     = d1_r[i][D_W-1] ? D_W'(-$signed(d1_r[i])) : d1_r[i];
      sq_nxt[i]   = SQ_W'(dmag[i]) * SQ_W'(dmag[i]);
      prod_nxt[i] = PROD_W'(dmag[i]) * PROD_W'(smag);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_tvalid;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1_r[i] <= in_tdata[i*W +: W];
        v1_r[i] <= in_tdata[(i+3)*W +: W];
        dneg2_r[i] <= d1_r[i][D_W-1];
      end
      d1_r    <= d_nxt;
      p2_r    <= p1_r;
      v2_r    <= v1_r;
      sq2_r   <= sq_nxt;
      prod2_r <= prod_nxt;
    end
  end

  // square root of squared distance, payload rides alongside
  logic [SQ_W-1:0]          sum2;
  logic [LEN_W-1:0]         len;
  logic [CARRY_LEN-1:0]     cvld_r;
  carry_t                   carry_r [CARRY_LEN];

  assign sum2 = sq2_r[0] + sq2_r[1] + sq2_r[2];

  pms_isqrt u_isqrt (
    .clk     (clk),
    .en      (en),
    .x_in    (sum2),
    .len_out (len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cvld_r <= '0;
    end else if (en) begin
      cvld_r <= {cvld_r[CARRY_LEN-2:0], vld2_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      carry_r[0] <= '{p: p2_r, v: v2_r, dneg: dneg2_r, prod: prod2_r};
      for (int s = 1; s < CARRY_LEN; s++) carry_r[s] <= carry_r[s-1];
    end
  end

  // divisor len * dist * dist
  logic [DIST_W-1:0] dist_nxt, dist_r;
  logic [P1_W-1:0]   p1m_r;
  logic [DEN_W-1:0]  den_r;

  always_comb begin
    if (len < LEN_W'(DIST_MIN)) dist_nxt = DIST_W'(DIST_MIN);
    else if (len > LEN_W'(DIST_MAX)) dist_nxt = DIST_W'(DIST_MAX);
    else dist_nxt = len[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= dist_nxt;
      p1m_r  <= P1_W'(len) * P1_W'(dist_nxt);
      den_r  <= DEN_W'(p1m_r) * DEN_W'(dist_r);
    end
  end

  logic [2:0][Q_W-1:0] q;

  pms_div u_div (
    .clk     (clk),
    .en      (en),
    .prod_in (carry_r[SQRT_STG+1].prod),
    .den_in  (den_r),
    .q_out   (q)
  );

  // integration
  carry_t              ce;
  logic                acc_vld_r, pos_vld_r;
  vec3_t               acc_p_r, acc_v_r, pos_p_r, pos_v_r, v_nxt, p_nxt;
  logic signed [W+4:0] a_sum;
  logic [W-1:0]        a_sat;

  assign ce = carry_r[CARRY_LEN-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_sum = '0;
      if (mode_r[MODE_GRAV]) a_sum = (W+5)'($signed(grav_r[i*W +: W]));
      if (mode_r[MODE_ATTR]) begin
        if (ce.dneg[i] != str_r[W-1]) a_sum = a_sum - (W+5)'(q[i]);
        else a_sum = a_sum + (W+5)'(q[i]);
      end
      a_sat    = sat20(SAT_W'(a_sum));
      v_nxt[i] = sat20(SAT_W'($signed(ce.v[i])) + SAT_W'($signed(a_sat)));
      p_nxt[i] = sat20(SAT_W'($signed(acc_p_r[i])) + SAT_W'($signed(acc_v_r[i])));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_vld_r <= 1'b0;
      pos_vld_r <= 1'b0;
    end else if (en) begin
      acc_vld_r <= cvld_r[CARRY_LEN-1];
      pos_vld_r <= acc_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_p_r <= ce.p;
      acc_v_r <= v_nxt;
      pos_p_r <= p_nxt;
      pos_v_r <= acc_v_r;
    end
  end

  // walls
  wall_cfg_t wcfg;
  vec3_t     wp, wv;

  assign wcfg.en  = mode_r[MODE_WALL];
  assign wcfg.lim = $signed({1'b0, half_r}) - $signed({1'b0, rad_r});
  assign wcfg.k   = $signed(K_W'(ONE_Q12)) - $signed({1'b0, fric_r});

  pms_walls u_walls (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .cfg     (wcfg),
    .vld_in  (pos_vld_r),
    .p_in    (pos_p_r),
    .v_in    (pos_v_r),
    .vld_out (out_tvalid),
    .p_out   (wp),
    .v_out   (wv)
  );

  assign out_tdata = {wv[2], wv[1], wv[0], wp[2], wp[1], wp[0]};

endmodule
